>>> design/tpm_pkg.sv
// shared types, codes and constants for the timer pool
package tpm_pkg;

  localparam int SLOT_W        = 4;
  localparam int DUR_W         = 32;
  localparam int CNT_W         = 4;
  localparam int DEF_NUM_SLOTS = 8;
  localparam int RES_DEPTH     = 8;
  localparam int RES_PTR_W     = 3;
  localparam int RES_CNT_W     = 4;

  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_START   = 3'd1;
  localparam logic [2:0] CMD_RESTART = 3'd2;
  localparam logic [2:0] CMD_STOP    = 3'd3;
  localparam logic [2:0] CMD_CANCEL  = 3'd4;
  localparam logic [2:0] CMD_QUERY   = 3'd5;

  localparam logic [1:0] EV_ACK    = 2'd0;
  localparam logic [1:0] EV_START  = 2'd1;
  localparam logic [1:0] EV_STOP   = 2'd2;
  localparam logic [1:0] EV_REJECT = 2'd3;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [SLOT_W-1:0] slot_id;
    logic [DUR_W-1:0]  duration;
    logic              repeat_req;
  } req_t;

  typedef struct packed {
    logic [1:0]        event_kind;
    logic [SLOT_W-1:0] event_slot;
    logic              is_active;
    logic [CNT_W-1:0]  free_count;
    logic              last;
  } res_t;

  typedef struct packed {
    logic             active;
    logic             rpt;
    logic [DUR_W-1:0] deadline;
  } slot_t;

  typedef struct packed {
    slot_t      nxt;
    logic       push;
    logic [1:0] kind;
    logic       act_bit;
    logic       take;
  } head_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN,
    ST_EMIT
  } state_t;

endpackage

>>> design/tpm_cell.sv
// one timer slot of the rotating ring
module tpm_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  tpm_pkg::slot_t d,
  output tpm_pkg::slot_t q
);
  import tpm_pkg::*;

  // deadline is payload, undefined until written
  always_ff @(posedge clk) begin
    if (rst) begin
      q.active <= 1'b0;
      q.rpt    <= 1'b0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

>>> design/tpm_head.sv
// update logic applied to the slot at the head of the ring
module tpm_head (
  input  tpm_pkg::slot_t            cur,
  input  tpm_pkg::req_t             rq,
  input  logic [tpm_pkg::SLOT_W-1:0] idx,
  input  logic [tpm_pkg::DUR_W-1:0]  now,
  input  logic                      found,
  output tpm_pkg::head_out_t        o
);
  import tpm_pkg::*;

  logic             hit;
  logic [DUR_W-1:0] sum;

  assign hit = (rq.slot_id == idx);
  assign sum = now + rq.duration;

  always_comb begin
    o.nxt     = cur;
    o.push    = 1'b0;
    o.kind    = EV_ACK;
    o.act_bit = 1'b0;
    o.take    = 1'b0;
    unique case (rq.cmd)
      CMD_TICK: begin
        if (cur.active) begin
          if (cur.deadline < now) begin
            o.nxt.active = 1'b0;
            o.push       = 1'b1;
            o.kind       = EV_STOP;
          end else if (cur.rpt) begin
            o.push = 1'b1;
            o.kind = EV_START;
          end
        end
      end
      CMD_START: begin
        // lowest free slot wins
        if (!found && !cur.active) begin
          o.nxt.active   = 1'b1;
          o.nxt.rpt      = rq.repeat_req;
          o.nxt.deadline = sum;
          o.push         = 1'b1;
          o.kind         = EV_ACK;
          o.take         = 1'b1;
        end
      end
      CMD_RESTART: begin
        if (hit) begin
          o.nxt.active   = 1'b1;
          o.nxt.deadline = sum;
          o.push         = 1'b1;
          o.kind         = EV_ACK;
        end
      end
      CMD_STOP: begin
        if (hit) begin
          o.nxt.active = 1'b0;
          o.push       = 1'b1;
          o.kind       = EV_STOP;
        end
      end
      CMD_CANCEL: begin
        if (hit) begin
          o.nxt.active = 1'b0;
          o.push       = 1'b1;
          o.kind       = EV_ACK;
        end
      end
      CMD_QUERY: begin
        if (hit) begin
          o.push    = 1'b1;
          o.kind    = EV_ACK;
          o.act_bit = cur.active;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> design/timer_pool_manager_core.sv
// Timer pool: NUM_SLOTS second-resolution timers held in a ring of cells that rotates one
// slot per cycle past a single update unit. A tick, a start, or a restart, stop, cancel or
// query with a valid id shifts all NUM_SLOTS slots past the unit, closes in ST_FIN, then
// the results follow one per cycle, each shown for exactly one cycle with strobe high; an
// invalid id or an unused code skips the rotation. busy stays high from the accepted
// request until the cycle of the final result (marked last), and the next request can be
// taken in the cycle after the final result. The receiver must take every result in the
// cycle it is shown. A tick yields at most eight results.
module timer_pool_manager_core #(
  parameter int NUM_SLOTS = tpm_pkg::DEF_NUM_SLOTS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  tpm_pkg::req_t req,
  output logic          strobe,
  output tpm_pkg::res_t res
);
  import tpm_pkg::*;

  state_t                state;
  state_t                state_next;
  req_t                  rq;
  logic [DUR_W-1:0]      now;
  logic [SLOT_W-1:0]     idx;
  logic                  found;
  logic [CNT_W-1:0]      free_cnt;
  logic [RES_CNT_W-1:0]  wr;
  logic [RES_PTR_W-1:0]  rd;
  logic [1:0]            buf_kind [RES_DEPTH];
  logic [SLOT_W-1:0]     buf_slot [RES_DEPTH];
  logic                  buf_act  [RES_DEPTH];
  slot_t                 cells    [NUM_SLOTS];
  head_out_t             ho;
  logic                  scan_end;
  logic                  reject_now;
  logic                  emit_last;
  logic                  shift;

  assign shift    = (state == ST_SCAN);
  assign scan_end = (idx == SLOT_W'(NUM_SLOTS - 1));

  // ring: each cell takes its upper neighbor, the top cell takes the updated head
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    slot_t d;
    if (i == NUM_SLOTS - 1) begin : g_top
      assign d = ho.nxt;
    end else begin : g_mid
      assign d = cells[i+1];
    end
    tpm_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .d     (d),
      .q     (cells[i])
    );
  end

  tpm_head u_head (
    .cur   (cells[0]),
    .rq    (rq),
    .idx   (idx),
    .now   (now),
    .found (found),
    .o     (ho)
  );

  always_comb begin
    reject_now = 1'b0;
    case (req.cmd) inside
      CMD_TICK, CMD_START: reject_now = 1'b0;
      CMD_RESTART, CMD_STOP, CMD_CANCEL, CMD_QUERY:
        reject_now = (req.slot_id >= SLOT_W'(NUM_SLOTS));
      default: reject_now = 1'b1;
    endcase
  end

  assign emit_last = ((RES_CNT_W'(rd) + RES_CNT_W'(1)) == wr);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = reject_now ? ST_EMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now      <= '0;
      idx      <= '0;
      found    <= 1'b0;
      free_cnt <= CNT_W'(NUM_SLOTS);
      wr       <= '0;
      rd       <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            idx   <= '0;
            found <= 1'b0;
            rd    <= '0;
            wr    <= reject_now ? RES_CNT_W'(1) : '0;
            if (req.cmd == CMD_TICK) begin
              now <= now + DUR_W'(1);
            end
          end
        end
        ST_SCAN: begin
          idx <= idx + SLOT_W'(1);
          if (ho.take) begin
            found <= 1'b1;
          end
          if (cells[0].active && !ho.nxt.active) begin
            free_cnt <= free_cnt + CNT_W'(1);
          end else if (!cells[0].active && ho.nxt.active) begin
            free_cnt <= free_cnt - CNT_W'(1);
          end
          if (ho.push && (wr < RES_CNT_W'(RES_DEPTH))) begin
            wr <= wr + RES_CNT_W'(1);
          end
        end
        ST_FIN: begin
          if (wr == '0) begin
            wr <= RES_CNT_W'(1);
          end
        end
        ST_EMIT: begin
          rd <= rd + RES_PTR_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // request capture and result buffer
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      rq          <= req;
      buf_kind[0] <= EV_REJECT;
      buf_slot[0] <= req.slot_id;
      buf_act[0]  <= 1'b0;
    end else if (state == ST_SCAN && ho.push && (wr < RES_CNT_W'(RES_DEPTH))) begin
      buf_kind[wr[RES_PTR_W-1:0]] <= ho.kind;
      buf_slot[wr[RES_PTR_W-1:0]] <= idx;
      buf_act[wr[RES_PTR_W-1:0]]  <= ho.act_bit;
    end else if (state == ST_FIN && wr == '0) begin
      // quiet tick acknowledges, full pool rejects a start
      buf_kind[0] <= (rq.cmd == CMD_TICK) ? EV_ACK : EV_REJECT;
      buf_slot[0] <= '0;
      buf_act[0]  <= 1'b0;
    end
  end

  assign busy           = (state != ST_IDLE);
  assign strobe         = (state == ST_EMIT);
  assign res.event_kind = buf_kind[rd];
  assign res.event_slot = buf_slot[rd];
  assign res.is_active  = buf_act[rd];
  assign res.free_count = free_cnt;
  assign res.last       = emit_last;

endmodule

>>> design/tpm_checker.sv
// port-level checks for the timer pool, bound to the top level
module tpm_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input tpm_pkg::req_t req,
  input logic          strobe,
  input tpm_pkg::res_t res
);
  import tpm_pkg::*;

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("result shown while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_burst: assert property (@(posedge clk) disable iff (rst)
    (strobe && !res.last) |=> strobe)
    else $error("gap inside a result burst");

  a_end: assert property (@(posedge clk) disable iff (rst)
    (strobe && res.last) |=> !busy)
    else $error("busy after final result");

  a_count: assert property (@(posedge clk) disable iff (rst)
    (strobe && $past(strobe) && !$past(res.last)) |->
      (res.free_count == $past(res.free_count)))
    else $error("free count changed inside a burst");

endmodule

bind timer_pool_manager_core tpm_checker u_tpm_checker (.*);
